FILE: src/fpi_pkg.sv
// Shared types, codes and saturation helper for the firework particle integrator.
package fpi_pkg;

    // Command codes of an input item.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_X = 3'd0;
    localparam logic [2:0] CFG_START_Y = 3'd1;
    localparam logic [2:0] CFG_START_Z = 3'd2;
    localparam logic [2:0] CFG_BURST   = 3'd3;
    localparam logic [2:0] CFG_AIM_X   = 3'd4;
    localparam logic [2:0] CFG_AIM_Y   = 3'd5;
    localparam logic [2:0] CFG_AIM_Z   = 3'd6;
    localparam logic [2:0] CFG_GRAVITY = 3'd7;

    // Width of one stored particle entry.
    localparam int ENTRY_W = 4 * 32 + 2 * 26;

    // Input beat.
    typedef struct packed {
        logic              command;
        logic [5:0]        slot;
        logic signed [15:0] spread_x;
        logic signed [15:0] spread_y;
        logic signed [15:0] spread_z;
        logic [15:0]       frame_time;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [5:0]         particle;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               exploding;
        logic               done_res;
        logic               last;
    } t_out;

    // One particle as held in memory; lateral terms are pre-scaled by the force.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vspeed;
        logic signed [25:0] lat_x;
        logic signed [25:0] lat_z;
    } t_entry;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_G,
        ST_LS,
        ST_L0,
        ST_L1,
        ST_L2,
        ST_P_RD,
        ST_P_A,
        ST_P_B,
        ST_P_C,
        ST_P_WB,
        ST_P_END,
        ST_R_RD,
        ST_R_CAP,
        ST_R_HOLD
    } t_state;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
        logic signed [31:0] r;
        if (v[45:31] == {15{v[45]}}) begin
            r = v[31:0];
        end else if (v[45]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

FILE: src/fpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: src/firework_particle_integrator_top.sv
// Load item: state LOAD writes the slot's entry if the slot is in range. Tick: setup states G and LS (plus
// L0, L1 and L2 in the launch stage), then an update pass over the particle memory of P_RD, P_A and P_WB
// per particle in launch, with P_B and P_C added in explode, and a closing state P_END, then a report pass
// of R_RD, R_CAP and R_HOLD per result beat; a finished tick goes straight to report. One item is worked
// at a time; the single-port read of the particle RAM sets the pace.
// Reset (synchronous, active low) restores registers, launch speed, stage and finished flag;
// the particle memory is not cleared and needs no clearing pass.
module firework_particle_integrator_top #(
    parameter int PARTICLES       = 64,
    parameter int LAUNCH_SPEED_Q  = 655360,
    parameter int LATERAL_FORCE_Q = 65536,
    parameter int SPEED_SCALE_Q   = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  fpi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fpi_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam int IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PARTICLES - 1);
    localparam logic signed [25:0] LF_S = 26'(LATERAL_FORCE_Q);
    localparam logic signed [25:0] SS_S = 26'(SPEED_SCALE_Q);
    localparam logic signed [31:0] LS_INIT = 32'(LAUNCH_SPEED_Q);

    fpi_pkg::t_state r_state, n_state;
    fpi_pkg::t_in    r_item;
    logic [IW-1:0]   r_idx;

    logic signed [31:0] r_start_x, r_start_y, r_start_z, r_burst;
    logic signed [15:0] r_aim_x, r_aim_y, r_aim_z;
    logic [15:0]        r_grav;

    logic signed [31:0] r_ls;
    logic               r_stage, r_finished, r_burst_hit, r_all_below;
    logic [23:0]        r_g;
    logic signed [31:0] r_vsn;
    fpi_pkg::t_entry    r_ent;
    logic signed [33:0] r_a_x, r_a_y, r_a_z;
    logic signed [34:0] r_b_x, r_b_y, r_b_z;
    logic signed [44:0] r_c_x, r_c_y, r_c_z;
    fpi_pkg::t_out      r_out;
    logic               r_out_valid;

    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr;
    fpi_pkg::t_entry    ram_wdata, w_rd;
    logic [fpi_pkg::ENTRY_W-1:0] w_rdata;

    logic               w_in_acc, w_out_acc, w_is_last;
    logic signed [45:0] w_g46;
    logic [31:0]        w_gprod;
    logic signed [16:0] w_ft;
    logic signed [31:0] w_lf32, w_vsn, w_ls_new;
    logic signed [47:0] w_pa_x, w_pa_y, w_pa_z;
    logic signed [33:0] w_bin_x, w_bin_y, w_bin_z;
    logic signed [50:0] w_pb_x, w_pb_y, w_pb_z;
    logic signed [60:0] w_pc_x, w_pc_y, w_pc_z;
    logic signed [31:0] w_nx, w_ny, w_nz;
    logic signed [41:0] w_lv_x, w_lv_y, w_lv_z;
    fpi_pkg::t_entry    w_load_ent;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;
    assign w_is_last = (r_idx == LAST_IDX);
    assign w_rd      = w_rdata;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Particle state memory.
    fpi_ram #(
        .WIDTH(fpi_pkg::ENTRY_W),
        .DEPTH(PARTICLES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    // Gravity step and launch speed update.
    assign w_gprod  = 32'(r_item.frame_time) * 32'(r_grav);
    assign w_g46    = {22'd0, r_g};
    assign w_ls_new = fpi_pkg::sat32(46'(r_ls) - w_g46);
    assign w_vsn    = fpi_pkg::sat32(46'(w_rd.vspeed) - w_g46);
    assign w_ft     = {1'b0, r_item.frame_time};

    // Direction scaling by the force for x and z and by the launch speed for y (launch setup only).
    assign w_lf32 = 32'(LF_S);
    assign w_pa_x = 48'(w_lf32) * 48'(r_aim_x);
    assign w_pa_y = 48'(r_ls) * 48'(r_aim_y);
    assign w_pa_z = 48'(w_lf32) * 48'(r_aim_z);

    // Frame time scaling: setup terms in launch, per-particle terms in explode.
    assign w_bin_x = (r_state == fpi_pkg::ST_L1) ? r_a_x : 34'(r_ent.lat_x);
    assign w_bin_y = (r_state == fpi_pkg::ST_L1) ? r_a_y : 34'(r_vsn);
    assign w_bin_z = (r_state == fpi_pkg::ST_L1) ? r_a_z : 34'(r_ent.lat_z);
    assign w_pb_x  = 51'(w_bin_x) * 51'(w_ft);
    assign w_pb_y  = 51'(w_bin_y) * 51'(w_ft);
    assign w_pb_z  = 51'(w_bin_z) * 51'(w_ft);

    // Speed scale.
    assign w_pc_x = 61'(r_b_x) * 61'(SS_S);
    assign w_pc_y = 61'(r_b_y) * 61'(SS_S);
    assign w_pc_z = 61'(r_b_z) * 61'(SS_S);

    // New positions.
    assign w_nx = fpi_pkg::sat32(46'(r_ent.pos_x) + 46'(r_c_x));
    assign w_ny = fpi_pkg::sat32(46'(r_ent.pos_y) + 46'(r_c_y));
    assign w_nz = fpi_pkg::sat32(46'(r_ent.pos_z) + 46'(r_c_z));

    // Entry for a load beat.
    assign w_lv_x = 42'(LF_S) * 42'(r_item.spread_x);
    assign w_lv_y = 42'(LF_S) * 42'(r_item.spread_y);
    assign w_lv_z = 42'(LF_S) * 42'(r_item.spread_z);
    always_comb begin
        w_load_ent.pos_x  = r_start_x;
        w_load_ent.pos_y  = r_start_y;
        w_load_ent.pos_z  = r_start_z;
        w_load_ent.vspeed = 32'($signed(w_lv_y[41:14]));
        w_load_ent.lat_x  = w_lv_x[39:14];
        w_load_ent.lat_z  = w_lv_z[39:14];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fpi_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.command == fpi_pkg::CMD_LOAD) begin
                        n_state = fpi_pkg::ST_LOAD;
                    end else if (r_finished) begin
                        n_state = fpi_pkg::ST_R_RD;
                    end else begin
                        n_state = fpi_pkg::ST_G;
                    end
                end
            end
            fpi_pkg::ST_LOAD: n_state = fpi_pkg::ST_IDLE;
            fpi_pkg::ST_G:    n_state = fpi_pkg::ST_LS;
            fpi_pkg::ST_LS:   n_state = r_stage ? fpi_pkg::ST_P_RD : fpi_pkg::ST_L0;
            fpi_pkg::ST_L0:   n_state = fpi_pkg::ST_L1;
            fpi_pkg::ST_L1:   n_state = fpi_pkg::ST_L2;
            fpi_pkg::ST_L2:   n_state = fpi_pkg::ST_P_RD;
            fpi_pkg::ST_P_RD: n_state = fpi_pkg::ST_P_A;
            fpi_pkg::ST_P_A:  n_state = r_stage ? fpi_pkg::ST_P_B : fpi_pkg::ST_P_WB;
            fpi_pkg::ST_P_B:  n_state = fpi_pkg::ST_P_C;
            fpi_pkg::ST_P_C:  n_state = fpi_pkg::ST_P_WB;
            fpi_pkg::ST_P_WB: n_state = w_is_last ? fpi_pkg::ST_P_END : fpi_pkg::ST_P_RD;
            fpi_pkg::ST_P_END: n_state = fpi_pkg::ST_R_RD;
            fpi_pkg::ST_R_RD:  n_state = fpi_pkg::ST_R_CAP;
            fpi_pkg::ST_R_CAP: n_state = fpi_pkg::ST_R_HOLD;
            fpi_pkg::ST_R_HOLD: begin
                if (w_out_acc) begin
                    n_state = w_is_last ? fpi_pkg::ST_IDLE : fpi_pkg::ST_R_RD;
                end
            end
            default: n_state = fpi_pkg::ST_IDLE;
        endcase
    end

    // State outputs: handshake and memory port control.
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = w_load_ent;
        case (r_state)
            fpi_pkg::ST_IDLE: o_in_ready = 1'b1;
            fpi_pkg::ST_LOAD: begin
                ram_waddr = r_item.slot[IW-1:0];
                ram_we    = (7'(r_item.slot) < 7'(PARTICLES));
            end
            fpi_pkg::ST_P_RD: ram_re = 1'b1;
            fpi_pkg::ST_R_RD: ram_re = 1'b1;
            fpi_pkg::ST_P_WB: begin
                ram_we           = 1'b1;
                ram_wdata.pos_x  = w_nx;
                ram_wdata.pos_y  = w_ny;
                ram_wdata.pos_z  = w_nz;
                ram_wdata.vspeed = r_vsn;
                ram_wdata.lat_x  = r_ent.lat_x;
                ram_wdata.lat_z  = r_ent.lat_z;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpi_pkg::ST_IDLE;
            r_idx       <= '0;
            r_ls        <= LS_INIT;
            r_stage     <= 1'b0;
            r_finished  <= 1'b0;
            r_burst_hit <= 1'b0;
            r_all_below <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                fpi_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_idx <= '0;
                    end
                end
                fpi_pkg::ST_G: begin
                    r_burst_hit <= 1'b0;
                    r_all_below <= 1'b1;
                end
                fpi_pkg::ST_LS: r_ls <= w_ls_new;
                fpi_pkg::ST_P_WB: begin
                    if (!r_stage && r_idx == '0 && w_ny >= r_burst) begin
                        r_burst_hit <= 1'b1;
                    end
                    if (w_ny >= r_start_y) begin
                        r_all_below <= 1'b0;
                    end
                    if (!w_is_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                fpi_pkg::ST_P_END: begin
                    r_idx <= '0;
                    if (r_stage) begin
                        r_finished <= r_all_below;
                    end else if (r_burst_hit) begin
                        r_stage <= 1'b1;
                    end
                end
                fpi_pkg::ST_R_CAP: r_out_valid <= 1'b1;
                fpi_pkg::ST_R_HOLD: begin
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (!w_is_last) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_burst   <= '0;
            r_aim_x   <= '0;
            r_aim_y   <= 16'sd16384;
            r_aim_z   <= '0;
            r_grav    <= 16'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fpi_pkg::CFG_START_X: r_start_x <= i_cfg_data;
                fpi_pkg::CFG_START_Y: r_start_y <= i_cfg_data;
                fpi_pkg::CFG_START_Z: r_start_z <= i_cfg_data;
                fpi_pkg::CFG_BURST:   r_burst   <= i_cfg_data;
                fpi_pkg::CFG_AIM_X:   r_aim_x   <= i_cfg_data[15:0];
                fpi_pkg::CFG_AIM_Y:   r_aim_y   <= i_cfg_data[15:0];
                fpi_pkg::CFG_AIM_Z:   r_aim_z   <= i_cfg_data[15:0];
                fpi_pkg::CFG_GRAVITY: r_grav    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == fpi_pkg::ST_G) begin
            r_g <= w_gprod[31:8];
        end
        if (r_state == fpi_pkg::ST_L0) begin
            r_a_x <= w_pa_x[47:14];
            r_a_y <= w_pa_y[47:14];
            r_a_z <= w_pa_z[47:14];
        end
        if (r_state == fpi_pkg::ST_L1 || r_state == fpi_pkg::ST_P_B) begin
            r_b_x <= w_pb_x[50:16];
            r_b_y <= w_pb_y[50:16];
            r_b_z <= w_pb_z[50:16];
        end
        if (r_state == fpi_pkg::ST_L2 || r_state == fpi_pkg::ST_P_C) begin
            r_c_x <= w_pc_x[60:16];
            r_c_y <= w_pc_y[60:16];
            r_c_z <= w_pc_z[60:16];
        end
        if (r_state == fpi_pkg::ST_P_A) begin
            r_ent <= w_rd;
            r_vsn <= w_vsn;
        end
        if (r_state == fpi_pkg::ST_R_CAP) begin
            r_out.particle  <= 6'(r_idx);
            r_out.pos_x     <= w_rd.pos_x;
            r_out.pos_y     <= w_rd.pos_y;
            r_out.pos_z     <= w_rd.pos_z;
            r_out.exploding <= r_stage;
            r_out.done_res  <= r_finished;
            r_out.last      <= w_is_last;
        end
    end

    // The last flag marks exactly the highest particle index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.particle == 6'(PARTICLES - 1))))
        else $error("last flag does not match final particle");

    // No new item is taken while a result beat is pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // Memory is never read and written in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write overlap");

    // The animation can only be finished in the explode stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> r_stage)
        else $error("finished outside explode stage");

    // Delivering the final beat of a tick frees the input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out_data.last) |=> o_in_ready)
        else $error("block not idle after final beat");

endmodule
